// ----- sv/psc_pkg.sv -----
`default_nettype none
package psc_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int ACC_WIDTH  = 48;

	localparam int TICK_W  = 16;
	localparam int LIM_W   = DATA_WIDTH - 1;
	localparam int DIFF_W  = DATA_WIDTH + 1;
	localparam int CH_W    = TICK_W;
	localparam int MUL_W   = DATA_WIDTH + CH_W + 1;
	localparam int OPD_MIN = (DIFF_W > ACC_WIDTH) ? DIFF_W : ACC_WIDTH;
	localparam int NCHUNK  = (OPD_MIN + CH_W - 1) / CH_W;
	localparam int OPD_W   = NCHUNK * CH_W;
	localparam int CNT_W   = $clog2(NCHUNK);
	localparam int PROD_W  = DATA_WIDTH + OPD_W;
	localparam int SUM_W   = PROD_W - FRAC_BITS + 2;
	localparam int ISUM_W  = ((ACC_WIDTH > MUL_W) ? ACC_WIDTH : MUL_W) + 1;

	localparam int CFG_IDX_W = 3;
	localparam logic [TICK_W-1:0] DEFAULT_PERIOD_RST = TICK_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN     = 3'd1,
		REG_DERIV_GAIN     = 3'd2,
		REG_INTEG_LIMIT    = 3'd3,
		REG_OUT_LIMIT      = 3'd4,
		REG_DEFAULT_PERIOD = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		TERM_TICKS,
		TERM_P,
		TERM_I,
		TERM_D
	} term_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] prop_gain;
		logic signed [DATA_WIDTH-1:0] integ_gain;
		logic signed [DATA_WIDTH-1:0] deriv_gain;
		logic [LIM_W-1:0]             integ_limit;
		logic [LIM_W-1:0]             out_limit;
		logic [TICK_W-1:0]            default_period;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic             err_en;
		logic             div_start;
		logic             sum_clr;
		logic             mul_en;
		logic             mul_acc;
		term_t            mul_term;
		logic [CNT_W-1:0] mul_chunk;
		logic             mul_last;
		logic             int_add;
		logic             int_clamp;
		logic             finish;
		logic             out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- sv/psc_div.sv -----
`default_nettype none
module psc_div import psc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [DIFF_W-1:0] num,
	input  wire logic [TICK_W-1:0]        den,
	output logic                          busy,
	output logic signed [DIFF_W-1:0]      quot
);

	localparam int DCNT_W = $clog2(DATA_WIDTH);

	logic                     busy_q;
	logic                     fix_q;
	logic [DCNT_W-1:0]        cnt_q;
	logic [TICK_W-1:0]        rem_q;
	logic [TICK_W-1:0]        den_q;
	logic [DATA_WIDTH-1:0]    quo_q;
	logic                     neg_q;
	logic signed [DIFF_W-1:0] quot_q;

	logic [DIFF_W-1:0] mag;
	logic [TICK_W:0]   trial;
	logic [TICK_W:0]   trial_sub;
	logic              fits;

	always_comb begin
		mag       = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
		trial     = {rem_q, quo_q[DATA_WIDTH-1]};
		trial_sub = trial - {1'b0, den_q};
		fits      = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fix_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (fix_q) begin
				busy_q <= 1'b0;
				fix_q  <= 1'b0;
			end else if (cnt_q == DCNT_W'(DATA_WIDTH - 1)) begin
				fix_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag[DATA_WIDTH-1:0];
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[DIFF_W-1];
		end else if (busy_q && !fix_q) begin
			rem_q <= fits ? trial_sub[TICK_W-1:0] : trial[TICK_W-1:0];
			quo_q <= {quo_q[DATA_WIDTH-2:0], fits};
		end else if (busy_q && fix_q) begin
			quot_q <= neg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

// ----- sv/psc_dp.sv -----
`default_nettype none
module psc_dp import psc_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dp_cmd_t                      cmd,
	input  wire cfg_t                         cfg,
	input  wire logic                         op,
	input  wire logic signed [DATA_WIDTH-1:0] setpoint,
	input  wire logic signed [DATA_WIDTH-1:0] measured,
	input  wire logic [TICK_W-1:0]            step_ticks,
	output dp_sts_t                           sts,
	output logic signed [DATA_WIDTH-1:0]      drive,
	output logic                              clamped
);

	logic signed [DATA_WIDTH-1:0] sp_q;
	logic signed [DATA_WIDTH-1:0] ms_q;
	logic [TICK_W-1:0]            ticks_q;
	logic signed [DATA_WIDTH-1:0] err_q;
	logic signed [DATA_WIDTH-1:0] last_err_q;
	logic signed [ACC_WIDTH-1:0]  integral_q;
	logic signed [ISUM_W-1:0]     isum_q;
	logic signed [MUL_W-1:0]      p_s1;
	logic [CNT_W-1:0]             k_s1;
	logic                         acc_en_s1;
	logic                         last_s1;
	logic signed [PROD_W-1:0]     acc_q;
	logic                         fin_s2;
	logic signed [SUM_W-1:0]      sum_q;
	logic signed [DATA_WIDTH-1:0] drv_q;
	logic                         clp_q;
	logic signed [DATA_WIDTH-1:0] drive_q;
	logic                         clamped_q;

	logic [TICK_W-1:0]            tk_sel;
	logic signed [DIFF_W-1:0]     dif;
	logic signed [DATA_WIDTH-1:0] err_sat;
	logic signed [DIFF_W-1:0]     div_num;
	logic signed [DIFF_W-1:0]     div_quot;
	logic                         div_busy;
	logic signed [OPD_W-1:0]      opd;
	logic [CH_W-1:0]              chunk;
	logic signed [DATA_WIDTH-1:0] mul_a;
	logic signed [CH_W:0]         mul_b;
	logic signed [MUL_W-1:0]      prod;
	logic signed [PROD_W-1:0]     addend;
	logic signed [PROD_W-1:0]     acc_sh;
	logic signed [ISUM_W-1:0]     ilim;
	logic signed [ISUM_W-1:0]     amax;
	logic signed [ISUM_W-1:0]     icl;
	logic signed [SUM_W-1:0]      olim;
	logic signed [SUM_W-1:0]      omax;
	logic signed [SUM_W-1:0]      ores;
	logic                         oclp;

	psc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (ticks_q),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_comb begin
		if (step_ticks != '0) begin
			tk_sel = step_ticks;
		end else if (cfg.default_period != '0) begin
			tk_sel = cfg.default_period;
		end else begin
			tk_sel = TICK_W'(1);
		end

		dif = DIFF_W'(sp_q) - DIFF_W'(ms_q);
		if (dif[DIFF_W-1] != dif[DIFF_W-2]) begin
			err_sat = {dif[DIFF_W-1], {(DATA_WIDTH-1){~dif[DIFF_W-1]}}};
		end else begin
			err_sat = dif[DATA_WIDTH-1:0];
		end
		div_num = DIFF_W'(err_q) - DIFF_W'(last_err_q);

		case (cmd.mul_term)
			TERM_P: begin
				mul_a = cfg.prop_gain;
				opd   = OPD_W'(err_q);
			end
			TERM_I: begin
				mul_a = cfg.integ_gain;
				opd   = OPD_W'(integral_q);
			end
			TERM_D: begin
				mul_a = cfg.deriv_gain;
				opd   = OPD_W'(div_quot);
			end
			default: begin
				mul_a = err_q;
				opd   = '0;
			end
		endcase
		chunk = opd[cmd.mul_chunk*CH_W +: CH_W];
		if (cmd.mul_term == TERM_TICKS) begin
			mul_b = signed'({1'b0, ticks_q});
		end else if (cmd.mul_chunk == CNT_W'(NCHUNK - 1)) begin
			mul_b = signed'({chunk[CH_W-1], chunk});
		end else begin
			mul_b = signed'({1'b0, chunk});
		end
		prod = mul_a * mul_b;

		addend = PROD_W'(p_s1) <<< (CH_W * k_s1);
		acc_sh = acc_q >>> FRAC_BITS;

		ilim = signed'(ISUM_W'(cfg.integ_limit));
		amax = signed'(ISUM_W'({(ACC_WIDTH-1){1'b1}}));
		if (cfg.integ_limit != '0) begin
			if (isum_q > ilim) begin
				icl = ilim;
			end else if (isum_q < -ilim) begin
				icl = -ilim;
			end else begin
				icl = isum_q;
			end
		end else begin
			if (isum_q > amax) begin
				icl = amax;
			end else if (isum_q < ~amax) begin
				icl = ~amax;
			end else begin
				icl = isum_q;
			end
		end

		olim = signed'(SUM_W'(cfg.out_limit));
		omax = signed'(SUM_W'({(DATA_WIDTH-1){1'b1}}));
		oclp = 1'b1;
		if (cfg.out_limit != '0) begin
			if (sum_q > olim) begin
				ores = olim;
			end else if (sum_q < -olim) begin
				ores = -olim;
			end else begin
				ores = sum_q;
				oclp = 1'b0;
			end
		end else begin
			if (sum_q > omax) begin
				ores = omax;
			end else if (sum_q < ~omax) begin
				ores = ~omax;
			end else begin
				ores = sum_q;
				oclp = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			last_err_q <= '0;
			acc_en_s1  <= 1'b0;
			fin_s2     <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.mul_en && cmd.mul_acc;
			fin_s2    <= acc_en_s1 && last_s1;
			if (cmd.load && op) begin
				integral_q <= '0;
				last_err_q <= '0;
			end else if (cmd.int_clamp) begin
				integral_q <= icl[ACC_WIDTH-1:0];
			end else if (cmd.finish) begin
				last_err_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sp_q    <= setpoint;
			ms_q    <= measured;
			ticks_q <= tk_sel;
		end
		if (cmd.load && op) begin
			drv_q <= '0;
			clp_q <= 1'b0;
		end else if (cmd.finish) begin
			drv_q <= ores[DATA_WIDTH-1:0];
			clp_q <= oclp;
		end
		if (cmd.err_en) begin
			err_q <= err_sat;
		end
		if (cmd.mul_en) begin
			p_s1    <= prod;
			k_s1    <= cmd.mul_chunk;
			last_s1 <= cmd.mul_last;
		end
		if (cmd.int_add) begin
			isum_q <= ISUM_W'(integral_q) + ISUM_W'(p_s1);
		end
		if (acc_en_s1) begin
			acc_q <= ((k_s1 == '0) ? '0 : acc_q) + addend;
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (fin_s2) begin
			sum_q <= sum_q + signed'(SUM_W'(acc_sh));
		end
		if (cmd.out_load) begin
			drive_q   <= drv_q;
			clamped_q <= clp_q;
		end
	end

	assign sts.div_busy = div_busy;
	assign drive        = drive_q;
	assign clamped      = clamped_q;

endmodule
`default_nettype wire

// ----- sv/psc_ctrl.sv -----
`default_nettype none
module psc_ctrl import psc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step_valid,
	input  wire logic    op,
	input  wire logic    result_stall,
	input  wire dp_sts_t sts,
	output logic         step_stall,
	output logic         result_valid,
	output dp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_DIFF,
		S_IADD,
		S_ICLAMP,
		S_PMUL,
		S_IMUL,
		S_DWAIT,
		S_DMUL,
		S_DRAIN,
		S_FIN,
		S_OUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             result_valid_q;
	logic             chunk_last;

	assign chunk_last = (cnt_q == CNT_W'(NCHUNK - 1));

	always_comb begin
		cmd           = '0;
		cmd.mul_term  = TERM_TICKS;
		cmd.mul_chunk = cnt_q;
		cmd.mul_last  = chunk_last;
		case (state_q)
			S_IDLE:   cmd.load = step_valid;
			S_ERR:    cmd.err_en = 1'b1;
			S_DIFF: begin
				cmd.div_start = 1'b1;
				cmd.sum_clr   = 1'b1;
				cmd.mul_en    = 1'b1;
			end
			S_IADD:   cmd.int_add = 1'b1;
			S_ICLAMP: cmd.int_clamp = 1'b1;
			S_PMUL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_acc  = 1'b1;
				cmd.mul_term = TERM_P;
			end
			S_IMUL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_acc  = 1'b1;
				cmd.mul_term = TERM_I;
			end
			S_DMUL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_acc  = 1'b1;
				cmd.mul_term = TERM_D;
			end
			S_FIN:    cmd.finish = 1'b1;
			S_OUT:    cmd.out_load = !result_valid_q || !result_stall;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (step_valid) begin
						state_q <= op ? S_OUT : S_ERR;
					end
				end
				S_ERR:    state_q <= S_DIFF;
				S_DIFF:   state_q <= S_IADD;
				S_IADD:   state_q <= S_ICLAMP;
				S_ICLAMP: state_q <= S_PMUL;
				S_PMUL: begin
					cnt_q <= chunk_last ? '0 : cnt_q + 1'b1;
					if (chunk_last) begin
						state_q <= S_IMUL;
					end
				end
				S_IMUL: begin
					cnt_q <= chunk_last ? '0 : cnt_q + 1'b1;
					if (chunk_last) begin
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					if (!sts.div_busy) begin
						state_q <= S_DMUL;
					end
				end
				S_DMUL: begin
					cnt_q <= chunk_last ? '0 : cnt_q + 1'b1;
					if (chunk_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (cnt_q == CNT_W'(1)) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN:    state_q <= S_OUT;
				S_OUT: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign step_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;

endmodule
`default_nettype wire

// ----- sv/pid_step_with_clamps.sv -----
// Channel  Handshake            Payload
// step     step_valid/stall     op, setpoint, measured, step_ticks
// result   result_valid/stall   drive, clamped
// config   cfg_valid/ready      cfg_index, cfg_data
//
// A compute item spends most of its time between accepts in the 32-step iterative
// divider that forms the derivative; the gain products share one 32x17 multiplier.
// A clear item goes straight to the output stage. One item is in work at a time, and
// the next item is taken while the previous result waits in the output register.
// While that result is stalled, the next finished item waits and the input stalls.
// Reset clears the integral and the last error and returns the registers to reset values.
`default_nettype none
module pid_step_with_clamps import psc_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step_valid,
	output logic                              step_stall,
	input  wire logic                         op,
	input  wire logic signed [DATA_WIDTH-1:0] setpoint,
	input  wire logic signed [DATA_WIDTH-1:0] measured,
	input  wire logic [TICK_W-1:0]            step_ticks,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic signed [DATA_WIDTH-1:0]      drive,
	output logic                              clamped,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [DATA_WIDTH-1:0]        cfg_data
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= '0;
			cfg_q.integ_gain     <= '0;
			cfg_q.deriv_gain     <= '0;
			cfg_q.integ_limit    <= '0;
			cfg_q.out_limit      <= '0;
			cfg_q.default_period <= DEFAULT_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:      cfg_q.prop_gain <= signed'(cfg_data);
				REG_INTEG_GAIN:     cfg_q.integ_gain <= signed'(cfg_data);
				REG_DERIV_GAIN:     cfg_q.deriv_gain <= signed'(cfg_data);
				REG_INTEG_LIMIT:    cfg_q.integ_limit <= cfg_data[LIM_W-1:0];
				REG_OUT_LIMIT:      cfg_q.out_limit <= cfg_data[LIM_W-1:0];
				REG_DEFAULT_PERIOD: cfg_q.default_period <= cfg_data[TICK_W-1:0];
				default:            ;
			endcase
		end
	end

	psc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_valid   (step_valid),
		.op           (op),
		.result_stall (result_stall),
		.sts          (sts),
		.step_stall   (step_stall),
		.result_valid (result_valid),
		.cmd          (cmd)
	);

	psc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.op         (op),
		.setpoint   (setpoint),
		.measured   (measured),
		.step_ticks (step_ticks),
		.sts        (sts),
		.drive      (drive),
		.clamped    (clamped)
	);

endmodule
`default_nettype wire

// ----- verif/pid_step_checker.sv -----
`timescale 1ns / 1ps
module pid_step_checker import psc_pkg::*; #(
	parameter logic OP_CLEAR = 1'b1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_valid,
	input  logic                         step_stall,
	input  logic                         op,
	input  logic signed [DATA_WIDTH-1:0] setpoint,
	input  logic signed [DATA_WIDTH-1:0] measured,
	input  logic [TICK_W-1:0]            step_ticks,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  logic signed [DATA_WIDTH-1:0] drive,
	input  logic                         clamped,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [DATA_WIDTH-1:0]        cfg_data,
	output int                           outstanding,
	output int                           mismatches
);

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] drive;
		logic                         clamped;
	} drive_out_t;

	drive_out_t                   pending_drives[$];
	logic signed [DATA_WIDTH-1:0] kp = '0;
	logic signed [DATA_WIDTH-1:0] ki = '0;
	logic signed [DATA_WIDTH-1:0] kd = '0;
	logic [LIM_W-1:0]             integ_lim = '0;
	logic [LIM_W-1:0]             drive_lim = '0;
	logic [TICK_W-1:0]            dflt_ticks = DEFAULT_PERIOD_RST;
	logic signed [ACC_WIDTH-1:0]  integ_acc = '0;
	logic signed [DATA_WIDTH-1:0] prev_err = '0;

	function automatic wide_t saturate(input wide_t v, input int w, output logic hit);
		wide_t hi_bound;
		wide_t lo_bound;
		hi_bound = (wide_t'(1) << (w - 1)) - 1;
		lo_bound = -hi_bound - 1;
		hit = 1'b1;
		if (v > hi_bound)
			return hi_bound;
		if (v < lo_bound)
			return lo_bound;
		hit = 1'b0;
		return v;
	endfunction

	function automatic drive_out_t pid_control_step(
		input logic                         kind,
		input logic signed [DATA_WIDTH-1:0] sp,
		input logic signed [DATA_WIDTH-1:0] ms,
		input logic [TICK_W-1:0]            ticks_in
	);
		drive_out_t res;
		wide_t      ticks;
		wide_t      err;
		wide_t      acc;
		wide_t      lim;
		wide_t      deriv;
		wide_t      total;
		wide_t      drv;
		logic       hit;
		res.drive   = '0;
		res.clamped = 1'b0;
		if (kind == OP_CLEAR) begin
			integ_acc = '0;
			prev_err  = '0;
			return res;
		end
		ticks = (ticks_in != '0) ? wide_t'(ticks_in) : wide_t'(dflt_ticks);
		if (ticks == 0)
			ticks = 1;
		err = saturate(wide_t'(sp) - wide_t'(ms), DATA_WIDTH, hit);
		acc = saturate(wide_t'(integ_acc) + err * ticks, ACC_WIDTH, hit);
		lim = wide_t'(integ_lim);
		if (lim != 0) begin
			if (acc > lim)
				acc = lim;
			else if (acc < -lim)
				acc = -lim;
		end
		// Signed division truncates toward zero, as the derivative requires.
		deriv = (err - wide_t'(prev_err)) / ticks;
		total = ((wide_t'(kp) * err) >>> FRAC_BITS)
			+ ((wide_t'(ki) * acc) >>> FRAC_BITS)
			+ ((wide_t'(kd) * deriv) >>> FRAC_BITS);
		drv = saturate(total, DATA_WIDTH, hit);
		lim = wide_t'(drive_lim);
		if (lim != 0) begin
			if (drv > lim) begin
				drv = lim;
				hit = 1'b1;
			end else if (drv < -lim) begin
				drv = -lim;
				hit = 1'b1;
			end
		end
		integ_acc   = acc[ACC_WIDTH-1:0];
		prev_err    = err[DATA_WIDTH-1:0];
		res.drive   = drv[DATA_WIDTH-1:0];
		res.clamped = hit;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_out_t want;
		int         bad;
		if (!arst_n) begin
			kp         = '0;
			ki         = '0;
			kd         = '0;
			integ_lim  = '0;
			drive_lim  = '0;
			dflt_ticks = DEFAULT_PERIOD_RST;
			integ_acc  = '0;
			prev_err   = '0;
			pending_drives.delete();
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROP_GAIN:      kp = cfg_data;
					REG_INTEG_GAIN:     ki = cfg_data;
					REG_DERIV_GAIN:     kd = cfg_data;
					REG_INTEG_LIMIT:    integ_lim = cfg_data[LIM_W-1:0];
					REG_OUT_LIMIT:      drive_lim = cfg_data[LIM_W-1:0];
					REG_DEFAULT_PERIOD: dflt_ticks = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (pending_drives.size() == 0) begin
					$error("drive: expected no item, actual %0d", drive);
					bad++;
				end else begin
					want = pending_drives.pop_front();
					if (drive !== want.drive) begin
						$error("drive: expected %0d, actual %0d", want.drive, drive);
						bad++;
					end
					if (clamped !== want.clamped) begin
						$error("clamped: expected %0b, actual %0b", want.clamped, clamped);
						bad++;
					end
				end
			end
			if (step_valid && !step_stall)
				pending_drives.push_back(pid_control_step(op, setpoint, measured, step_ticks));
			outstanding <= pending_drives.size();
			mismatches  <= mismatches + bad;
		end
	end

endmodule

// ----- verif/tb_pid_step_with_clamps.sv -----
`timescale 1ns / 1ps
module tb_pid_step_with_clamps;
	import psc_pkg::*;

	localparam logic OP_COMPUTE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;
	localparam logic signed [DATA_WIDTH-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_WIDTH-1:0] S_MIN = 32'sh8000_0000;
	localparam logic [DATA_WIDTH-1:0]        U_LIM = 32'h7FFF_FFFF;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         step_valid = 1'b0;
	logic                         step_stall;
	logic                         op = OP_COMPUTE;
	logic signed [DATA_WIDTH-1:0] setpoint = '0;
	logic signed [DATA_WIDTH-1:0] measured = '0;
	logic [TICK_W-1:0]            step_ticks = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	logic signed [DATA_WIDTH-1:0] drive;
	logic                         clamped;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [DATA_WIDTH-1:0]        cfg_data = '0;
	int                           outstanding;
	int                           mismatches;

	logic                         tx_idle_on = 1'b1;
	logic                         rx_idle_on = 1'b1;
	int                           hold_seq = 0;
	logic signed [DATA_WIDTH-1:0] target = '0;

	pid_step_with_clamps i_dut (.*);

	pid_step_checker #(.OP_CLEAR(OP_CLEAR)) i_checker (.*);

	always #1 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return S_MIN;
			2: return S_MAX;
			3, 4: return $urandom;
			default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	function automatic logic [DATA_WIDTH-1:0] pick_limit();
		case ($urandom_range(0, 7))
			0, 1: return '0;
			2: return U_LIM;
			3: return '1;
			4: return $urandom;
			default: return $urandom_range(1, 32'h0100_0000);
		endcase
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] pick_value(
		input logic signed [DATA_WIDTH-1:0] base
	);
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return S_MAX;
			2: return S_MIN;
			default: return base + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	function automatic logic [TICK_W-1:0] pick_ticks();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return TICK_W'($urandom);
			default: return TICK_W'($urandom_range(1, 16));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_WIDTH-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic apply_config(
		input logic [DATA_WIDTH-1:0] p_gain,
		input logic [DATA_WIDTH-1:0] i_gain,
		input logic [DATA_WIDTH-1:0] d_gain,
		input logic [DATA_WIDTH-1:0] i_lim,
		input logic [DATA_WIDTH-1:0] o_lim,
		input logic [DATA_WIDTH-1:0] period
	);
		write_reg(REG_PROP_GAIN, p_gain);
		write_reg(REG_INTEG_GAIN, i_gain);
		write_reg(REG_DERIV_GAIN, d_gain);
		write_reg(REG_INTEG_LIMIT, i_lim);
		write_reg(REG_OUT_LIMIT, o_lim);
		write_reg(REG_DEFAULT_PERIOD, period);
		// Writes to the unused indexes must leave the settings alone.
		for (int k = REG_DEFAULT_PERIOD + 1; k < 2 ** CFG_IDX_W; k++)
			write_reg(CFG_IDX_W'(k), $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_step(
		input logic                         kind,
		input logic signed [DATA_WIDTH-1:0] sp,
		input logic signed [DATA_WIDTH-1:0] ms,
		input logic [TICK_W-1:0]            tk
	);
		int gap;
		gap = tx_idle_on ? idle_len() : 0;
		if (gap > 0) begin
			step_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		step_valid <= 1'b1;
		op         <= kind;
		setpoint   <= sp;
		measured   <= ms;
		step_ticks <= tk;
		do
			@(posedge clk);
		while (step_stall);
	endtask

	task automatic wait_drained();
		step_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin : result_side
		int len;
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
				result_stall <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				len = idle_len();
				if (len > 0) begin
					result_stall <= 1'b1;
					repeat (len) @(posedge clk);
				end
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		logic kind;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset settings give no drive but still build up the integral.
		send_step(OP_COMPUTE, 32'sh0064_0000, '0, '0);
		wait_drained();

		apply_config(32'h0001_0000, 32'h0000_0100, 32'h0001_0000, '0, '0, 9);
		send_step(OP_COMPUTE, S_MAX, S_MIN, '0);
		send_step(OP_COMPUTE, S_MIN, S_MAX, '1);
		repeat (4) send_step(OP_COMPUTE, S_MAX, S_MIN, '1);
		send_step(OP_CLEAR, $urandom, $urandom, TICK_W'($urandom));
		send_step(OP_COMPUTE, -32'sd1, '0, 3);
		send_step(OP_COMPUTE, 32'sd7, '0, 2);
		send_step(OP_COMPUTE, '0, '0, 1);
		wait_drained();

		// Drive equal to the output limit is not clamped, one past it is.
		apply_config(32'h0001_0000, '0, '0, U_LIM, 32'h1234_5678, '0);
		send_step(OP_COMPUTE, 32'sh1234_5678, '0, '0);
		send_step(OP_COMPUTE, 32'sh1234_5679, '0, '0);
		send_step(OP_COMPUTE, '0, 32'sh1234_5678, '0);
		send_step(OP_COMPUTE, '0, 32'sh1234_5679, '0);
		send_step(OP_CLEAR, S_MIN, S_MAX, '1);
		wait_drained();

		apply_config(S_MIN, S_MAX, S_MIN, 1, U_LIM, 16'hFFFF);
		send_step(OP_COMPUTE, S_MAX, S_MIN, 1);
		send_step(OP_COMPUTE, S_MIN, S_MAX, '0);
		send_step(OP_COMPUTE, '0, '0, '1);
		send_step(OP_COMPUTE, 32'sh0000_8000, 32'shFFFF_8000, 2);
		send_step(OP_CLEAR, '0, '0, '0);

		// Hold off the results long enough for the block to back up.
		wait_drained();
		tx_idle_on = 1'b0;
		rx_idle_on <= 1'b0;
		hold_seq   <= hold_seq + 1;
		repeat (6) send_step(OP_COMPUTE, pick_value('0), pick_value('0), pick_ticks());

		for (int phase = 0; phase < 8; phase++) begin
			wait_drained();
			if (phase == 0)
				apply_config(S_MAX, S_MAX, S_MAX, '0, '0, 1);
			else
				apply_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
					($urandom_range(0, 5) == 0) ? '0 : $urandom_range(1, 32'hFFFF));
			tx_idle_on = (phase % 3 != 2);
			rx_idle_on <= (phase % 3 != 1);
			for (int n = 0; n < 178; n++) begin
				if (n % 25 == 0)
					target = ($urandom_range(0, 4) == 0) ? $urandom
						: $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
				kind = ($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_COMPUTE;
				send_step(kind, ($urandom_range(0, 9) == 0) ? pick_value(target) : target,
					pick_value(target), pick_ticks());
			end
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
